FILE: hdl/nrtp_pkg.sv
// Types and constants shared by the nested region time profiler.
// Used by nrtp_ctrl, nrtp_datapath and nested_region_time_profiler_unit.
package nrtp_pkg;

   localparam int ID_W        = 6;
   localparam int DATA_W      = 64;
   localparam int CODE_W      = 2;
   localparam int REQ_TDATA_W = 136;
   localparam int RSP_TDATA_W = 264;

   localparam logic [CODE_W-1:0] KIND_ENTER = 2'd0;
   localparam logic [CODE_W-1:0] KIND_EXIT  = 2'd1;
   localparam logic [CODE_W-1:0] KIND_READ  = 2'd2;

   localparam logic [CODE_W-1:0] RSP_OK    = 2'd0;
   localparam logic [CODE_W-1:0] RSP_FULL  = 2'd1;
   localparam logic [CODE_W-1:0] RSP_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ENTER,
      ST_REPORT,
      ST_EX_STACK,
      ST_EX_PARENT,
      ST_EX_SELF
   } state_type;

   typedef struct packed {
      logic [DATA_W-1:0] bytes;
      logic [DATA_W-1:0] hits;
      logic [DATA_W-1:0] excl;
      logic [DATA_W-1:0] incl;
   } entry_type;

   typedef struct packed {
      logic              idle;
      logic              clear_wr;
      logic              accept;
      logic              enter_commit;
      logic              stack_step;
      logic              parent_commit;
      logic              exit_commit;
      logic              report;
      logic [CODE_W-1:0] rsp_code;
   } cmd_type;

   typedef struct packed {
      logic              clear_done;
      logic              stack_full;
      logic              stack_empty;
      logic              out_free;
      logic [CODE_W-1:0] in_kind;
      logic [CODE_W-1:0] held_kind;
   } status_type;

endpackage

FILE: hdl/nested_region_time_profiler_unit.sv
// Top level of the nested region time profiler: port packing and checks.
// Depends on nrtp_pkg, nrtp_ctrl and nrtp_datapath.
//
//   channel | direction | tuser          | tdata
//   req     | in        | req_type       | anchor_id, bytes_in_region, timestamp
//   rsp     | out       | status         | result_anchor, inclusive, exclusive, hits, bytes
//
// An enter or read item steps through accept, then load of the result register.
// An exit item steps through accept, stack pop with the elapsed subtraction, then two
// read-modify-writes (parent, then anchor) on the anchor table, which has one read and
// one write port. The result shows in the cycle after the last step.
// After reset a clearing pass zeroes all ANCHOR_COUNT anchor table entries, with
// req_tready low. Items are taken one at a time; a result waiting on rsp_tready
// holds the block in its last step, while the next item is accepted once the
// result sits in the output register.
module nested_region_time_profiler_unit #(
   parameter int ANCHOR_COUNT = 64,
   parameter int NEST_DEPTH   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // anchor_id[5:0], bytes_in_region[69:6], timestamp[133:70], zero fill
   input  logic [nrtp_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // req_type[1:0]
   input  logic [nrtp_pkg::CODE_W-1:0]         req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // result_anchor[5:0], inclusive_ticks[69:6], exclusive_ticks[133:70],
   // hit_total[197:134], byte_total[261:198], zero fill
   output logic [nrtp_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // status[1:0]
   output logic [nrtp_pkg::CODE_W-1:0]         rsp_tuser
);
   import nrtp_pkg::*;

   cmd_type           cmd;
   status_type        st;
   logic [ID_W-1:0]   result_anchor;
   logic [DATA_W-1:0] inclusive_ticks, exclusive_ticks, hit_total, byte_total;

   nrtp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .st         (st),
      .cmd        (cmd)
   );

   nrtp_datapath #(
      .ANCHOR_COUNT (ANCHOR_COUNT),
      .NEST_DEPTH   (NEST_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_type        (req_tuser),
      .anchor_id       (req_tdata[ID_W-1:0]),
      .bytes_in_region (req_tdata[ID_W+DATA_W-1:ID_W]),
      .timestamp       (req_tdata[ID_W+2*DATA_W-1:ID_W+DATA_W]),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .status          (rsp_tuser),
      .result_anchor   (result_anchor),
      .inclusive_ticks (inclusive_ticks),
      .exclusive_ticks (exclusive_ticks),
      .hit_total       (hit_total),
      .byte_total      (byte_total)
   );

   assign req_tready = cmd.idle;
   assign rsp_tdata  = {(RSP_TDATA_W - ID_W - 4 * DATA_W)'(0), byte_total, hit_total,
                        exclusive_ticks, inclusive_ticks, result_anchor};

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while another is in work");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.enter_commit || cmd.exit_commit || cmd.report) |-> st.out_free)
      else $error("result loaded over a waiting result");

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_wr, cmd.accept, cmd.enter_commit, cmd.stack_step,
                cmd.parent_commit, cmd.exit_commit, cmd.report}))
      else $error("datapath commands overlap");

   a_stack_level: assert property (@(posedge clock) disable iff (reset)
      st.stack_full |-> !st.stack_empty)
      else $error("stack level inconsistent");

endmodule

FILE: hdl/nrtp_ctrl.sv
// Controller state machine of the profiler: sequences clear, enter, exit and read.
// Depends on nrtp_pkg; drives nrtp_datapath through cmd_type.
module nrtp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  nrtp_pkg::status_type st,
   output nrtp_pkg::cmd_type    cmd
);
   import nrtp_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (st.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.idle = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (st.in_kind == KIND_ENTER) begin
                  state_in = st.stack_full ? ST_REPORT : ST_ENTER;
               end else if (st.in_kind == KIND_EXIT) begin
                  state_in = st.stack_empty ? ST_REPORT : ST_EX_STACK;
               end else begin
                  state_in = ST_REPORT;
               end
            end
         end
         ST_ENTER: begin
            if (st.out_free) begin
               cmd.enter_commit = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         ST_REPORT: begin
            if (st.out_free) begin
               cmd.report = 1'b1;
               if (st.held_kind == KIND_ENTER) begin
                  cmd.rsp_code = RSP_FULL;
               end else if (st.held_kind == KIND_EXIT) begin
                  cmd.rsp_code = RSP_EMPTY;
               end else begin
                  cmd.rsp_code = RSP_OK;
               end
               state_in = ST_IDLE;
            end
         end
         ST_EX_STACK: begin
            cmd.stack_step = 1'b1;
            state_in       = ST_EX_PARENT;
         end
         ST_EX_PARENT: begin
            cmd.parent_commit = 1'b1;
            state_in          = ST_EX_SELF;
         end
         ST_EX_SELF: begin
            if (st.out_free) begin
               cmd.exit_commit = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/nrtp_datapath.sv
// Datapath of the profiler: region stack, anchor table, elapsed arithmetic, result register.
// Depends on nrtp_pkg; commanded by nrtp_ctrl.
module nrtp_datapath #(
   parameter int ANCHOR_COUNT = 64,
   parameter int NEST_DEPTH   = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  nrtp_pkg::cmd_type                  cmd,
   output nrtp_pkg::status_type               st,
   input  logic [nrtp_pkg::CODE_W-1:0]        req_type,
   input  logic [nrtp_pkg::ID_W-1:0]          anchor_id,
   input  logic [nrtp_pkg::DATA_W-1:0]        bytes_in_region,
   input  logic [nrtp_pkg::DATA_W-1:0]        timestamp,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [nrtp_pkg::CODE_W-1:0]        status,
   output logic [nrtp_pkg::ID_W-1:0]          result_anchor,
   output logic [nrtp_pkg::DATA_W-1:0]        inclusive_ticks,
   output logic [nrtp_pkg::DATA_W-1:0]        exclusive_ticks,
   output logic [nrtp_pkg::DATA_W-1:0]        hit_total,
   output logic [nrtp_pkg::DATA_W-1:0]        byte_total
);
   import nrtp_pkg::*;

   localparam int AW   = $clog2(ANCHOR_COUNT);
   localparam int LW   = $clog2(NEST_DEPTH + 1);
   localparam int SW   = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
   localparam int SE_W = 2 * AW + 2 * DATA_W;

   // anchor id reduced modulo the table size
   logic [AW-1:0] mod_tab [2**ID_W];
   for (genvar g = 0; g < 2**ID_W; g++) begin : g_mod
      assign mod_tab[g] = AW'(g % ANCHOR_COUNT);
   end

   entry_type         anchor_mem [ANCHOR_COUNT];
   logic [SE_W-1:0]   stack_mem [NEST_DEPTH];

   entry_type         rdata_ff;
   logic [SE_W-1:0]   stack_rd_ff;

   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   entry_type         mem_wdata;
   logic              stack_we, stack_re;

   logic [CODE_W-1:0] kind_ff, kind_in;
   logic [AW-1:0]     a_ff, a_in;
   logic [DATA_W-1:0] bytes_ff, bytes_in;
   logic [DATA_W-1:0] now_ff, now_in;
   logic [LW-1:0]     level_ff, level_in;
   logic [AW-1:0]     parent_ff, parent_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [AW-1:0]     p_ff, p_in;
   logic [AW-1:0]     s_ff, s_in;
   logic [DATA_W-1:0] sincl_ff, sincl_in;
   logic [DATA_W-1:0] elapsed_ff, elapsed_in;
   entry_type         pwr_ff, pwr_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0] rsp_code_ff, rsp_code_in;
   logic [AW-1:0]     rsp_anchor_ff, rsp_anchor_in;
   entry_type         rsp_entry_ff, rsp_entry_in;

   logic [LW-1:0]     level_m1;
   logic [AW-1:0]     lookup;
   logic [AW-1:0]     stk_parent, stk_anchor;
   logic [DATA_W-1:0] stk_incl, stk_start;
   entry_type         enter_word, parent_word, self_base, self_word;
   logic              out_free;

   assign lookup     = mod_tab[anchor_id];
   assign level_m1   = level_ff - LW'(1);
   assign stk_start  = stack_rd_ff[DATA_W-1:0];
   assign stk_incl   = stack_rd_ff[2*DATA_W-1:DATA_W];
   assign stk_anchor = stack_rd_ff[2*DATA_W+AW-1:2*DATA_W];
   assign stk_parent = stack_rd_ff[SE_W-1:2*DATA_W+AW];
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign st.clear_done  = (clr_ff == AW'(ANCHOR_COUNT - 1));
   assign st.stack_full  = (level_ff == LW'(NEST_DEPTH));
   assign st.stack_empty = (level_ff == '0);
   assign st.out_free    = out_free;
   assign st.in_kind     = req_type;
   assign st.held_kind   = kind_ff;

   always_comb begin
      enter_word       = rdata_ff;
      enter_word.bytes = rdata_ff.bytes + bytes_ff;
      parent_word      = rdata_ff;
      parent_word.excl = rdata_ff.excl - elapsed_ff;
      self_base        = (s_ff == p_ff) ? pwr_ff : rdata_ff;
      self_word        = self_base;
      self_word.excl   = self_base.excl + elapsed_ff;
      self_word.incl   = sincl_ff + elapsed_ff;
      self_word.hits   = self_base.hits + DATA_W'(1);
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = a_ff;
      mem_raddr = a_ff;
      mem_wdata = '0;
      stack_we  = 1'b0;
      stack_re  = 1'b0;

      kind_in    = kind_ff;
      a_in       = a_ff;
      bytes_in   = bytes_ff;
      now_in     = now_ff;
      level_in   = level_ff;
      parent_in  = parent_ff;
      clr_in     = clr_ff;
      p_in       = p_ff;
      s_in       = s_ff;
      sincl_in   = sincl_ff;
      elapsed_in = elapsed_ff;
      pwr_in     = pwr_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_code_in   = rsp_code_ff;
      rsp_anchor_in = rsp_anchor_ff;
      rsp_entry_in  = rsp_entry_ff;

      if (cmd.clear_wr) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
         clr_in    = clr_ff + AW'(1);
      end

      if (cmd.accept) begin
         kind_in   = req_type;
         bytes_in  = bytes_in_region;
         now_in    = timestamp;
         a_in      = (req_type == KIND_EXIT) ? parent_ff : lookup;
         mem_re    = 1'b1;
         mem_raddr = a_in;
         stack_re  = (req_type == KIND_EXIT) && (level_ff != '0);
      end

      if (cmd.enter_commit) begin
         stack_we      = 1'b1;
         level_in      = level_ff + LW'(1);
         parent_in     = a_ff;
         mem_we        = 1'b1;
         mem_waddr     = a_ff;
         mem_wdata     = enter_word;
         rsp_valid_in  = 1'b1;
         rsp_code_in   = cmd.rsp_code;
         rsp_anchor_in = a_ff;
         rsp_entry_in  = enter_word;
      end

      if (cmd.stack_step) begin
         p_in       = stk_parent;
         s_in       = stk_anchor;
         sincl_in   = stk_incl;
         elapsed_in = now_ff - stk_start;
         level_in   = level_m1;
         parent_in  = stk_parent;
         mem_re     = 1'b1;
         mem_raddr  = stk_parent;
      end

      if (cmd.parent_commit) begin
         mem_we    = 1'b1;
         mem_waddr = p_ff;
         mem_wdata = parent_word;
         pwr_in    = parent_word;
         mem_re    = 1'b1;
         mem_raddr = s_ff;
      end

      if (cmd.exit_commit) begin
         mem_we        = 1'b1;
         mem_waddr     = s_ff;
         mem_wdata     = self_word;
         rsp_valid_in  = 1'b1;
         rsp_code_in   = cmd.rsp_code;
         rsp_anchor_in = s_ff;
         rsp_entry_in  = self_word;
      end

      if (cmd.report) begin
         rsp_valid_in  = 1'b1;
         rsp_code_in   = cmd.rsp_code;
         rsp_anchor_in = a_ff;
         rsp_entry_in  = rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         anchor_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= anchor_mem[mem_raddr];
      end
      if (stack_we) begin
         stack_mem[level_ff[SW-1:0]] <= {parent_ff, a_ff, rdata_ff.incl, now_ff};
      end
      if (stack_re) begin
         stack_rd_ff <= stack_mem[level_m1[SW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         parent_ff    <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         parent_ff    <= parent_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      a_ff          <= a_in;
      bytes_ff      <= bytes_in;
      now_ff        <= now_in;
      p_ff          <= p_in;
      s_ff          <= s_in;
      sincl_ff      <= sincl_in;
      elapsed_ff    <= elapsed_in;
      pwr_ff        <= pwr_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_anchor_ff <= rsp_anchor_in;
      rsp_entry_ff  <= rsp_entry_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign status          = rsp_code_ff;
   assign result_anchor   = ID_W'(rsp_anchor_ff);
   assign inclusive_ticks = rsp_entry_ff.incl;
   assign exclusive_ticks = rsp_entry_ff.excl;
   assign hit_total       = rsp_entry_ff.hits;
   assign byte_total      = rsp_entry_ff.bytes;

endmodule
